[sv/baro_pkg.sv]
// ----------------------------------------------------------------------------
// baro_pkg
// Shared types, codes and helpers of the barometer compensation block.
// ----------------------------------------------------------------------------
package baro_pkg;

    localparam int DataW = 32;
    localparam int AddrW = 6;

    localparam logic [2:0] REG_COEF_A    = 3'd0;
    localparam logic [2:0] REG_COEF_B    = 3'd1;
    localparam logic [2:0] REG_COEF_LIN  = 3'd2;
    localparam logic [2:0] REG_COEF_TEMP = 3'd3;
    localparam logic [2:0] REG_OSS       = 3'd4;

    localparam logic [31:0] B6_OFFSET  = 32'd4000;
    localparam logic [31:0] B4_OFFSET  = 32'd32768;
    localparam logic [31:0] B7_SCALE   = 32'd50000;
    localparam logic [31:0] MG_COEF    = 32'd3038;
    localparam logic [31:0] MH_COEF    = 32'hFFFF_E343;
    localparam logic [31:0] MI_COEF    = 32'd3791;
    localparam logic [31:0] SIGN_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic        req_type;
        logic [23:0] raw_value;
    } t_in;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] value;
        logic               div_error;
    } t_out;

    typedef struct packed {
        logic [15:0] ac1;
        logic [15:0] ac2;
        logic [15:0] ac3;
        logic [15:0] ac4;
        logic [15:0] ac5;
        logic [15:0] ac6;
        logic [15:0] b1;
        logic [15:0] b2;
        logic [15:0] mc;
        logic [15:0] md;
        logic [1:0]  oss;
    } t_coef;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_T_X1, OP_T_DEN, OP_T_FIN,
        OP_P_SQ, OP_P_X1A, OP_P_X2A, OP_P_B3, OP_P_X1B, OP_P_X2B, OP_P_X3,
        OP_P_B4, OP_P_B7, OP_P_DIV, OP_P_P, OP_P_C1, OP_P_C2, OP_P_C3,
        OP_P_C4, OP_P_RES
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_T_X1, S_T_DEN, S_T_DIV, S_T_FIN,
        S_P_SQ, S_P_X1A, S_P_X2A, S_P_B3, S_P_X1B, S_P_X2B, S_P_X3,
        S_P_B4, S_P_B7, S_P_DIV, S_P_DWAIT, S_P_P, S_P_C1, S_P_C2, S_P_C3,
        S_P_C4, S_P_RES, S_FIN
    } t_state;

    typedef struct packed {
        t_op  op;
        logic out_set;
    } t_cmd;

    typedef struct packed {
        logic den_zero;
        logic b4_zero;
        logic div_busy;
    } t_stat;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
        return 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

endpackage

[sv/barometer_compensation.sv]
// ----------------------------------------------------------------------------
// barometer_compensation
// Temperature and pressure compensation of a barometric sensor, 32-bit fixed
// point, with an APB configuration port for the calibration words.
//
//   channel   signals                               dir
//   input     i_in_valid / o_in_ready / i_in_data    in
//   result    o_out_valid / i_out_ready / o_out_data out
//   config    psel penable pwrite paddr pwdata ...   in/out
//
// Each beat runs its steps in order from accept to the next ready; the
// bit-serial divider and the single shared multiplier set how long it takes.
// A zero divisor skips the division and the steps after it, for both beats.
// One beat at a time; the next beat is taken while a result waits.
// Synchronous active-low reset clears the config, control and b5 registers.
// A stalled result holds the sequencer in its final step.
// ----------------------------------------------------------------------------
module barometer_compensation (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  baro_pkg::t_in             i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output baro_pkg::t_out            o_out_data,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [baro_pkg::AddrW-1:0] paddr,
    input  logic [63:0]               pwdata,
    output logic [63:0]               prdata,
    output logic                      pready
);
    import baro_pkg::*;

    logic [47:0] r_coef_a, r_coef_b;
    logic [31:0] r_coef_lin, r_coef_temp;
    logic [1:0]  r_oss;
    logic        w_wr;
    t_coef       w_coef;
    t_cmd        w_cmd;
    t_stat       w_stat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a    <= '0;
            r_coef_b    <= '0;
            r_coef_lin  <= '0;
            r_coef_temp <= '0;
            r_oss       <= '0;
        end else if (w_wr) begin
            case (paddr[5:3])
                REG_COEF_A:    r_coef_a    <= pwdata[47:0];
                REG_COEF_B:    r_coef_b    <= pwdata[47:0];
                REG_COEF_LIN:  r_coef_lin  <= pwdata[31:0];
                REG_COEF_TEMP: r_coef_temp <= pwdata[31:0];
                REG_OSS:       r_oss       <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_COEF_A:    prdata = {16'b0, r_coef_a};
            REG_COEF_B:    prdata = {16'b0, r_coef_b};
            REG_COEF_LIN:  prdata = {32'b0, r_coef_lin};
            REG_COEF_TEMP: prdata = {32'b0, r_coef_temp};
            REG_OSS:       prdata = {62'b0, r_oss};
            default:       prdata = '0;
        endcase
    end

    assign w_coef.ac1 = r_coef_a[47:32];
    assign w_coef.ac2 = r_coef_a[31:16];
    assign w_coef.ac3 = r_coef_a[15:0];
    assign w_coef.ac4 = r_coef_b[47:32];
    assign w_coef.ac5 = r_coef_b[31:16];
    assign w_coef.ac6 = r_coef_b[15:0];
    assign w_coef.b1  = r_coef_lin[31:16];
    assign w_coef.b2  = r_coef_lin[15:0];
    assign w_coef.mc  = r_coef_temp[31:16];
    assign w_coef.md  = r_coef_temp[15:0];
    assign w_coef.oss = r_oss;

    baro_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_data.req_type),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    baro_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .i_coef     (w_coef),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

[sv/baro_div.sv]
// ----------------------------------------------------------------------------
// baro_div
// Unsigned 32/32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module baro_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_quotient
);
    import baro_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_dsr;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [32:0] w_trial;

    always_comb begin
        w_trial = {r_rem, r_quo[31]} - {1'b0, r_dsr};
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_dividend;
            n_cnt  = 6'(DataW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt  = r_cnt - 6'd1;
            n_busy = (r_cnt != 6'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[sv/baro_datapath.sv]
// ----------------------------------------------------------------------------
// baro_datapath
// Compensation registers, one shared multiplier and the divider.
// ----------------------------------------------------------------------------
module baro_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  baro_pkg::t_cmd  i_cmd,
    input  baro_pkg::t_in   i_in_data,
    input  baro_pkg::t_coef i_coef,
    output baro_pkg::t_stat o_stat,
    output baro_pkg::t_out  o_out_data
);
    import baro_pkg::*;

    logic        r_kind;
    logic [23:0] r_raw;
    logic [31:0] r_b5, r_b6, r_up, r_sq, r_x1, r_x2, r_b3, r_b4, r_b7, r_p, r_res;
    logic        r_err, r_neg;
    t_out        r_out;

    logic [31:0] w_mul_a, w_mul_b, w_prod;
    logic [31:0] w_den, w_num, w_q, w_b5;
    logic [31:0] w_dvd, w_dsr, w_quo;
    logic        w_start, w_busy;

    assign w_den = r_x1 + sx16(i_coef.md);
    assign w_num = {{5{i_coef.mc[15]}}, i_coef.mc, 11'b0};
    assign w_q   = r_neg ? (32'd0 - w_quo) : w_quo;
    assign w_b5  = r_x1 + w_q;

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_T_X1:  begin w_mul_a = {16'b0, r_raw[15:0]} - {16'b0, i_coef.ac6};
                            w_mul_b = {16'b0, i_coef.ac5}; end
            OP_P_SQ:  begin w_mul_a = r_b6;               w_mul_b = r_b6; end
            OP_P_X1A: begin w_mul_a = r_sq;               w_mul_b = sx16(i_coef.b2); end
            OP_P_X2A: begin w_mul_a = sx16(i_coef.ac2);   w_mul_b = r_b6; end
            OP_P_X1B: begin w_mul_a = sx16(i_coef.ac3);   w_mul_b = r_b6; end
            OP_P_X2B: begin w_mul_a = sx16(i_coef.b1);    w_mul_b = r_sq; end
            OP_P_B4:  begin w_mul_a = {16'b0, i_coef.ac4}; w_mul_b = r_x1 + B4_OFFSET; end
            OP_P_B7:  begin w_mul_a = r_up - r_b3;        w_mul_b = B7_SCALE >> i_coef.oss; end
            OP_P_C2:  begin w_mul_a = r_x1;               w_mul_b = r_x1; end
            OP_P_C3:  begin w_mul_a = r_x1;               w_mul_b = MG_COEF; end
            OP_P_C4:  begin w_mul_a = r_p;                w_mul_b = MH_COEF; end
            default:  begin w_mul_a = '0;                 w_mul_b = '0; end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    always_comb begin
        w_start = 1'b0;
        w_dvd   = '0;
        w_dsr   = '0;
        if (i_cmd.op == OP_T_DEN) begin
            w_start = (w_den != 32'd0);
            w_dvd   = w_num[31] ? (32'd0 - w_num) : w_num;
            w_dsr   = w_den[31] ? (32'd0 - w_den) : w_den;
        end else if (i_cmd.op == OP_P_DIV) begin
            w_start = 1'b1;
            w_dvd   = (r_b7 < SIGN_LIMIT) ? {r_b7[30:0], 1'b0} : r_b7;
            w_dsr   = r_b4;
        end
    end

    baro_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .o_busy     (w_busy),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b5 <= '0;
        end else if (i_cmd.op == OP_T_FIN) begin
            r_b5 <= w_b5;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_kind <= i_in_data.req_type;
                r_raw  <= i_in_data.raw_value;
                r_err  <= 1'b0;
                r_res  <= '0;
                r_b6   <= r_b5 - B6_OFFSET;
                r_up   <= {8'b0, i_in_data.raw_value} >> (4'd8 - {2'b0, i_coef.oss});
            end
            OP_T_X1:  r_x1 <= asr32(w_prod, 5'd15);
            OP_T_DEN: begin
                r_neg <= w_num[31] ^ w_den[31];
                if (w_den == 32'd0) begin
                    r_err <= 1'b1;
                end
            end
            OP_T_FIN: r_res <= asr32(w_b5 + 32'd8, 5'd4);
            OP_P_SQ:  r_sq <= asr32(w_prod, 5'd12);
            OP_P_X1A: r_x1 <= asr32(w_prod, 5'd11);
            OP_P_X2A: r_x2 <= asr32(w_prod, 5'd11);
            OP_P_B3:  r_b3 <= asr32((((sx16(i_coef.ac1) << 2) + r_x1 + r_x2) << i_coef.oss)
                                    + 32'd2, 5'd2);
            OP_P_X1B: r_x1 <= asr32(w_prod, 5'd13);
            OP_P_X2B: r_x2 <= asr32(w_prod, 5'd16);
            OP_P_X3:  r_x1 <= asr32(r_x1 + r_x2 + 32'd2, 5'd2);
            OP_P_B4:  r_b4 <= w_prod >> 15;
            OP_P_B7: begin
                r_b7  <= w_prod;
                r_neg <= 1'b0;
                if (r_b4 == 32'd0) begin
                    r_err <= 1'b1;
                end
            end
            OP_P_P:   r_p  <= r_b7[31] ? {w_quo[30:0], 1'b0} : w_quo;
            OP_P_C1:  r_x1 <= asr32(r_p, 5'd8);
            OP_P_C2:  r_x1 <= w_prod;
            OP_P_C3:  r_x1 <= asr32(w_prod, 5'd16);
            OP_P_C4:  r_x2 <= asr32(w_prod, 5'd16);
            OP_P_RES: r_res <= r_p + asr32(r_x1 + r_x2 + MI_COEF, 5'd4);
            default: ;
        endcase
        if (i_cmd.out_set) begin
            r_out.result_kind <= r_kind;
            r_out.value       <= r_res;
            r_out.div_error   <= r_err;
        end
    end

    assign o_stat.den_zero = (w_den == 32'd0);
    assign o_stat.b4_zero  = (r_b4 == 32'd0);
    assign o_stat.div_busy = w_busy;
    assign o_out_data      = r_out;

endmodule

[sv/baro_ctrl.sv]
// ----------------------------------------------------------------------------
// baro_ctrl
// Sequencer for the compensation steps and the result handshake.
// ----------------------------------------------------------------------------
module baro_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req_type,
    input  logic           i_out_ready,
    input  baro_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output logic           o_out_valid,
    output baro_pkg::t_cmd  o_cmd
);
    import baro_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.op      = OP_NONE;
        o_cmd.out_set = 1'b0;
        o_in_ready    = 1'b0;
        n_out_valid   = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = i_req_type ? S_P_SQ : S_T_X1;
                end
            end
            S_T_X1:  begin o_cmd.op = OP_T_X1; n_state = S_T_DEN; end
            S_T_DEN: begin
                o_cmd.op = OP_T_DEN;
                n_state  = i_stat.den_zero ? S_FIN : S_T_DIV;
            end
            S_T_DIV: if (!i_stat.div_busy) begin
                n_state = S_T_FIN;
            end
            S_T_FIN:  begin o_cmd.op = OP_T_FIN;  n_state = S_FIN; end
            S_P_SQ:   begin o_cmd.op = OP_P_SQ;   n_state = S_P_X1A; end
            S_P_X1A:  begin o_cmd.op = OP_P_X1A;  n_state = S_P_X2A; end
            S_P_X2A:  begin o_cmd.op = OP_P_X2A;  n_state = S_P_B3; end
            S_P_B3:   begin o_cmd.op = OP_P_B3;   n_state = S_P_X1B; end
            S_P_X1B:  begin o_cmd.op = OP_P_X1B;  n_state = S_P_X2B; end
            S_P_X2B:  begin o_cmd.op = OP_P_X2B;  n_state = S_P_X3; end
            S_P_X3:   begin o_cmd.op = OP_P_X3;   n_state = S_P_B4; end
            S_P_B4:   begin o_cmd.op = OP_P_B4;   n_state = S_P_B7; end
            S_P_B7: begin
                o_cmd.op = OP_P_B7;
                n_state  = i_stat.b4_zero ? S_FIN : S_P_DIV;
            end
            S_P_DIV:  begin o_cmd.op = OP_P_DIV;  n_state = S_P_DWAIT; end
            S_P_DWAIT: if (!i_stat.div_busy) begin
                n_state = S_P_P;
            end
            S_P_P:    begin o_cmd.op = OP_P_P;    n_state = S_P_C1; end
            S_P_C1:   begin o_cmd.op = OP_P_C1;   n_state = S_P_C2; end
            S_P_C2:   begin o_cmd.op = OP_P_C2;   n_state = S_P_C3; end
            S_P_C3:   begin o_cmd.op = OP_P_C3;   n_state = S_P_C4; end
            S_P_C4:   begin o_cmd.op = OP_P_C4;   n_state = S_P_RES; end
            S_P_RES:  begin o_cmd.op = OP_P_RES;  n_state = S_FIN; end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_set = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("result dropped before it was taken");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_set |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_state != S_IDLE)
        else $error("accepted beat not started");

endmodule
